@@ sv/mfe_pkg.sv @@
package mfe_pkg;

  // Field and CORDIC geometry
  localparam int FIELD_BITS    = 21;
  localparam int CORDIC_STAGES = 24;
  localparam int GUARD_BITS    = 60 - FIELD_BITS;   // scale of vectors entering the CORDIC
  localparam int HFRAC_BITS    = 32 - FIELD_BITS;   // fraction bits of the fixed-point H root

  // Squares and root radicands
  localparam int SQ_BITS   = 2 * FIELD_BITS - 1;           // |v|^2 of one component
  localparam int SUM_BITS  = SQ_BITS + 1;                  // n^2+e^2(+d^2)
  localparam int RAD_BITS  = SUM_BITS + 2 * HFRAC_BITS;    // radicand after fraction scaling
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int REM_BITS  = ROOT_BITS + 1;
  localparam int SQRT_STEPS = ROOT_BITS;

  // CORDIC datapath
  localparam int CW        = 62;   // x/y width, holds gain growth of a 2^59.5 vector
  localparam int ZW        = 33;   // angle accumulator, 2^-24 degree
  localparam int STG_BITS  = 5;
  localparam int OUT_SHIFT = 8;    // 2^-24 deg -> 2^-16 deg

  // Output angle formats
  localparam int DEC_W = 25;
  localparam int INC_W = 24;
  localparam logic signed [ZW-1:0]    ANG90   = 33'sd1509949440;
  localparam logic signed [DEC_W-1:0] DEC_MAX = 25'sd11796480;
  localparam logic signed [INC_W-1:0] INC_MAX = 24'sd5898240;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
    logic [RAD_BITS-1:0]  rad;
  } sqrt_t;

  // round(atan(2^-i) * 2^24) degrees
  function automatic logic [ZW-1:0] atan_deg24(input logic [STG_BITS-1:0] i);
    logic [ZW-1:0] a;
    unique case (i)
      5'd0:  a = ZW'(754974720);
      5'd1:  a = ZW'(445687602);
      5'd2:  a = ZW'(235489088);
      5'd3:  a = ZW'(119537938);
      5'd4:  a = ZW'(60000934);
      5'd5:  a = ZW'(30029717);
      5'd6:  a = ZW'(15018523);
      5'd7:  a = ZW'(7509720);
      5'd8:  a = ZW'(3754917);
      5'd9:  a = ZW'(1877466);
      5'd10: a = ZW'(938734);
      5'd11: a = ZW'(469367);
      5'd12: a = ZW'(234684);
      5'd13: a = ZW'(117342);
      5'd14: a = ZW'(58671);
      5'd15: a = ZW'(29335);
      5'd16: a = ZW'(14668);
      5'd17: a = ZW'(7334);
      5'd18: a = ZW'(3667);
      5'd19: a = ZW'(1833);
      5'd20: a = ZW'(917);
      5'd21: a = ZW'(458);
      5'd22: a = ZW'(229);
      5'd23: a = ZW'(115);
      5'd24: a = ZW'(57);
      5'd25: a = ZW'(29);
      5'd26: a = ZW'(14);
      5'd27: a = ZW'(7);
      5'd28: a = ZW'(4);
      5'd29: a = ZW'(2);
      5'd30: a = ZW'(1);
      5'd31: a = '0;
    endcase
    return a;
  endfunction

  // Round 2^-24 deg to nearest 2^-16 deg (ties up), clamp to +-lim
  function automatic logic signed [DEC_W-1:0] to_out_units(input logic signed [ZW-1:0] z,
                                                           input logic signed [DEC_W-1:0] lim);
    logic signed [ZW:0]           t;
    logic signed [ZW-OUT_SHIFT:0] r;
    logic signed [ZW-OUT_SHIFT:0] lx;
    logic signed [DEC_W-1:0]      res;
    t  = {z[ZW-1], z} + (ZW+1)'(1 << (OUT_SHIFT - 1));
    r  = t[ZW:OUT_SHIFT];
    lx = {lim[DEC_W-1], lim};
    if (r > lx) begin
      res = lim;
    end else if (r < -lx) begin
      res = -lim;
    end else begin
      res = DEC_W'(r);
    end
    return res;
  endfunction

endpackage

@@ sv/mfe_sqrt_cell.sv @@
module mfe_sqrt_cell import mfe_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t sin_i,
  output sqrt_t sout_o
);

  logic [REM_BITS+1:0] rem_n;
  logic [REM_BITS+1:0] trial;
  logic [REM_BITS+1:0] diff;
  logic                ge;
  sqrt_t               sout_d;
  sqrt_t               sout_q;

  // one result bit per cell: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_n = {sin_i.rem, sin_i.rad[RAD_BITS-1 -: 2]};
    trial = {1'b0, sin_i.root, 2'b01};
    diff  = rem_n - trial;
    ge    = (rem_n >= trial);
    sout_d.rem  = ge ? diff[REM_BITS-1:0] : rem_n[REM_BITS-1:0];
    sout_d.root = {sin_i.root[ROOT_BITS-2:0], ge};
    sout_d.rad  = {sin_i.rad[RAD_BITS-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sout_q <= sout_d;
    end
  end

  assign sout_o = sout_q;

endmodule

@@ sv/mfe_cordic_cell.sv @@
module mfe_cordic_cell import mfe_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [STG_BITS-1:0] stage_i,
  input  cordic_t             cin_i,
  output cordic_t             cout_o
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic [ZW-1:0]        ang;
  cordic_t              cout_d;
  cordic_t              cout_q;

  // vectoring step: drive y toward zero, floor shifts
  always_comb begin
    xs  = $signed(cin_i.x) >>> stage_i;
    ys  = $signed(cin_i.y) >>> stage_i;
    ang = atan_deg24(stage_i);
    if (!cin_i.y[CW-1]) begin
      cout_d.x = cin_i.x + ys;
      cout_d.y = cin_i.y - xs;
      cout_d.z = cin_i.z + ang;
    end else begin
      cout_d.x = cin_i.x - ys;
      cout_d.y = cin_i.y + xs;
      cout_d.z = cin_i.z - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cout_q <= cout_d;
    end
  end

  assign cout_o = cout_q;

endmodule

@@ sv/magnetic_field_elements.sv @@
// Magnetic field elements from one north/east/down sample (signed nT): horizontal
// intensity H and total intensity F, rounded to the nearest nT, declination
// atan2(east, north) and inclination atan2(down, H) in signed units of 2^-16 degree.
// When H is at or below pole_threshold the sample is flagged at_pole, declination
// reads 0 and inclination reads +90, -90 or 0 degrees by the sign of down; both
// magnitudes are still reported. The block is a fully unrolled pipeline and takes
// one sample per clock while not stalled; a result passes through 1 square stage,
// 1 sum stage, 32 square-root cells, 24 inclination CORDIC cells and the output
// register, with the declination CORDIC running beside the root cells.
// Output backpressure stalls the pipeline only when the last stage and the output
// register both hold results; while the output waits the chain keeps shifting
// until a result reaches the last stage, then the whole chain holds.
// pole_threshold is written through its own valid/ready port, always ready, and
// should only change while no sample is in flight.
module magnetic_field_elements import mfe_pkg::*; (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic        [FIELD_BITS-1:0]   pole_threshold_i,
  // sample in
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [FIELD_BITS-1:0]   north_nt_i,
  input  logic signed [FIELD_BITS-1:0]   east_nt_i,
  input  logic signed [FIELD_BITS-1:0]   down_nt_i,
  // result out
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic        [FIELD_BITS-1:0]   horizontal_nt_o,
  output logic        [FIELD_BITS-1:0]   total_nt_o,
  output logic signed [DEC_W-1:0]        declination_o,
  output logic signed [INC_W-1:0]        inclination_o,
  output logic                           at_pole_o
);

  // Stage map: st0 squares/pre-rotation, st1 radicands, root cells end at ST_ROOT,
  // declination rounded at ST_DEC, inclination CORDIC ends at ST_LAST.
  localparam int ST_ROOT = 1 + SQRT_STEPS;
  localparam int ST_DEC  = CORDIC_STAGES + 1;
  localparam int ST_LAST = ST_ROOT + CORDIC_STAGES;
  localparam int NSTG    = ST_LAST + 1;

  // padding to place values at the CORDIC scale
  localparam int ROT_PAD = CW - (FIELD_BITS + 1) - GUARD_BITS;
  localparam int D_PAD   = CW - FIELD_BITS - GUARD_BITS;
  localparam int H_LSB   = GUARD_BITS - HFRAC_BITS;
  localparam int H_PAD   = CW - ROOT_BITS - H_LSB;

  logic                        adv;          // whole pipeline moves
  logic [NSTG-1:0]             vld_q;
  logic [FIELD_BITS-1:0]       thr_q;

  // st0
  logic [SQ_BITS-1:0]          sqn_q, sqe_q, sqd_q;
  logic signed [FIELD_BITS:0]  rx_q, ry_q;
  logic signed [ZW-1:0]        rz_q;
  logic signed [2*FIELD_BITS-1:0] pn, pe, pd;
  logic signed [FIELD_BITS:0]  nx, ex, rx_d, ry_d;
  logic signed [ZW-1:0]        rz_d;

  // st1
  logic [SUM_BITS-1:0]         s2_d, s3_d;
  logic [RAD_BITS-1:0]         radh_q, radf_q;

  // side payload carried along the chain
  logic signed [FIELD_BITS-1:0] d_q   [0:ST_LAST];
  logic signed [DEC_W-1:0]      dec_q [ST_DEC:ST_LAST];
  logic [FIELD_BITS-1:0]        h_q   [ST_ROOT+1:ST_LAST];
  logic [FIELD_BITS-1:0]        f_q   [ST_ROOT+1:ST_LAST];
  logic [FIELD_BITS-1:0]        h_d, f_d;

  // cell chains
  cordic_t dec_c [0:CORDIC_STAGES];
  cordic_t inc_c [0:CORDIC_STAGES];
  sqrt_t   hsq   [0:SQRT_STEPS];
  sqrt_t   fsq   [0:SQRT_STEPS];

  // output register
  logic                        out_vld_q, out_vld_d;
  logic [FIELD_BITS-1:0]       horiz_q, total_q;
  logic signed [DEC_W-1:0]     decl_q, decl_d;
  logic signed [INC_W-1:0]     incl_q, incl_d;
  logic                        pole_q, pole_d;
  logic signed [DEC_W-1:0]     inc_full;
  logic signed [FIELD_BITS-1:0] d_last;

  // ---------------------------------------------------------------------------
  // Flow control: shift when the tail is empty or the output slot frees up
  // ---------------------------------------------------------------------------
  assign adv         = !vld_q[ST_LAST] || !out_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= pole_threshold_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: squares and declination quadrant fold
  // ---------------------------------------------------------------------------
  always_comb begin
    pn = north_nt_i * north_nt_i;
    pe = east_nt_i * east_nt_i;
    pd = down_nt_i * down_nt_i;
    nx = {north_nt_i[FIELD_BITS-1], north_nt_i};
    ex = {east_nt_i[FIELD_BITS-1], east_nt_i};
    // negative north: turn by -90 (east >= 0) or +90 so CORDIC sees x >= 0;
    // negative north with zero east lands on +180
    if (!north_nt_i[FIELD_BITS-1]) begin
      rx_d = nx;
      ry_d = ex;
      rz_d = '0;
    end else if (!east_nt_i[FIELD_BITS-1]) begin
      rx_d = ex;
      ry_d = -nx;
      rz_d = ANG90;
    end else begin
      rx_d = -ex;
      ry_d = nx;
      rz_d = -ANG90;
    end
  end

  // radicands carry 2*HFRAC_BITS fraction bits; rounding falls out of the root
  always_comb begin
    s2_d = SUM_BITS'(sqn_q) + SUM_BITS'(sqe_q);
    s3_d = s2_d + SUM_BITS'(sqd_q);
  end

  // ---------------------------------------------------------------------------
  // Payload registers (no reset)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqn_q  <= pn[SQ_BITS-1:0];
      sqe_q  <= pe[SQ_BITS-1:0];
      sqd_q  <= pd[SQ_BITS-1:0];
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      rz_q   <= rz_d;
      radh_q <= {s2_d, {(2*HFRAC_BITS){1'b0}}};
      radf_q <= {s3_d, {(2*HFRAC_BITS){1'b0}}};

      d_q[0] <= down_nt_i;
      for (int k = 1; k <= ST_LAST; k++) begin
        d_q[k] <= d_q[k-1];
      end

      dec_q[ST_DEC] <= to_out_units(dec_c[CORDIC_STAGES].z, DEC_MAX);
      for (int k = ST_DEC + 1; k <= ST_LAST; k++) begin
        dec_q[k] <= dec_q[k-1];
      end

      h_q[ST_ROOT+1] <= h_d;
      f_q[ST_ROOT+1] <= f_d;
      for (int k = ST_ROOT + 2; k <= ST_LAST; k++) begin
        h_q[k] <= h_q[k-1];
        f_q[k] <= f_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Declination CORDIC: starts from st0, runs beside the root cells
  // ---------------------------------------------------------------------------
  assign dec_c[0].x = {{ROT_PAD{rx_q[FIELD_BITS]}}, rx_q, {GUARD_BITS{1'b0}}};
  assign dec_c[0].y = {{ROT_PAD{ry_q[FIELD_BITS]}}, ry_q, {GUARD_BITS{1'b0}}};
  assign dec_c[0].z = rz_q;

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_dec
    mfe_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .stage_i (STG_BITS'(j)),
      .cin_i   (dec_c[j]),
      .cout_o  (dec_c[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Root cells: floor(sqrt(s * 4^HFRAC_BITS)) for H and F, one bit per cell
  // ---------------------------------------------------------------------------
  assign hsq[0] = '{rem: '0, root: '0, rad: radh_q};
  assign fsq[0] = '{rem: '0, root: '0, rad: radf_q};

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_root
    mfe_sqrt_cell u_h (
      .clk_i  (clk_i),
      .en_i   (adv),
      .sin_i  (hsq[j]),
      .sout_o (hsq[j+1])
    );
    mfe_sqrt_cell u_f (
      .clk_i  (clk_i),
      .en_i   (adv),
      .sin_i  (fsq[j]),
      .sout_o (fsq[j+1])
    );
  end

  // nearest integer: drop the fraction, add its top bit
  always_comb begin
    h_d = hsq[SQRT_STEPS].root[ROOT_BITS-1:HFRAC_BITS]
        + FIELD_BITS'(hsq[SQRT_STEPS].root[HFRAC_BITS-1]);
    f_d = fsq[SQRT_STEPS].root[ROOT_BITS-1:HFRAC_BITS]
        + FIELD_BITS'(fsq[SQRT_STEPS].root[HFRAC_BITS-1]);
  end

  // ---------------------------------------------------------------------------
  // Inclination CORDIC: x = fixed-point H, y = down
  // ---------------------------------------------------------------------------
  assign inc_c[0].x = {{H_PAD{1'b0}}, hsq[SQRT_STEPS].root, {H_LSB{1'b0}}};
  assign inc_c[0].y = {{D_PAD{d_q[ST_ROOT][FIELD_BITS-1]}}, d_q[ST_ROOT], {GUARD_BITS{1'b0}}};
  assign inc_c[0].z = '0;

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_inc
    mfe_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .stage_i (STG_BITS'(j)),
      .cin_i   (inc_c[j]),
      .cout_o  (inc_c[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output stage: pole override and result register
  // ---------------------------------------------------------------------------
  always_comb begin
    d_last   = d_q[ST_LAST];
    inc_full = to_out_units(inc_c[CORDIC_STAGES].z, DEC_W'(INC_MAX));
    pole_d   = (h_q[ST_LAST] <= thr_q);
    if (pole_d) begin
      decl_d = '0;
      if (d_last[FIELD_BITS-1]) begin
        incl_d = -INC_MAX;
      end else if (d_last != '0) begin
        incl_d = INC_MAX;
      end else begin
        incl_d = '0;
      end
    end else begin
      decl_d = dec_q[ST_LAST];
      incl_d = INC_W'(inc_full);
    end
    out_vld_d = (adv && vld_q[ST_LAST]) || (out_vld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && vld_q[ST_LAST]) begin
      horiz_q <= h_q[ST_LAST];
      total_q <= f_q[ST_LAST];
      decl_q  <= decl_d;
      incl_q  <= incl_d;
      pole_q  <= pole_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign horizontal_nt_o = horiz_q;
  assign total_nt_o      = total_q;
  assign declination_o   = decl_q;
  assign inclination_o   = incl_q;
  assign at_pole_o       = pole_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a finished item at the tail moves into the output slot when the chain shifts
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_LAST] && adv |=> out_valid_o)
    else $error("tail item not handed to output register");

  // F can never be below H
  a_total_ge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> total_nt_o >= horizontal_nt_o)
    else $error("total intensity below horizontal intensity");

  a_pole_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_pole_o |-> declination_o == '0)
    else $error("declination not zeroed at pole");

  a_pole_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && at_pole_o |->
      (inclination_o == INC_MAX || inclination_o == -INC_MAX || inclination_o == '0))
    else $error("inclination not forced at pole");

endmodule
